// ===== design/scwf_pkg.sv =====
`default_nettype none

package scwf_pkg;

    // operation codes carried on the operation port
    localparam logic [1:0] OP_CLIP = 2'd0;
    localparam logic [1:0] OP_WRAP = 2'd1;
    localparam logic [1:0] OP_FOLD = 2'd2;
    localparam logic [1:0] OP_PASS = 2'd3;

    typedef logic [1:0] op_t;

endpackage

`default_nettype wire

// ===== design/sample_clip_wrap_fold.sv =====
`default_nettype none

// Channel   Handshake               Payload
// --------  ----------------------  ------------------------------------------------
// command   start, busy             sample_in, lower_bound, upper_bound, operation
// result    done (one-cycle pulse)  sample_out
//
// One transaction enters per cycle; busy is always low. A command is
// registered at entry, then passes through the remainder pipeline, which
// resolves one quotient bit per register stage, and the finish registers.
// rst_n clears the valid bits of every stage only.
// The receiver cannot stall: done pulses for exactly one cycle per result.
module sample_clip_wrap_fold #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  wire logic signed [SAMPLE_WIDTH-1:0] lower_bound,
    input  wire logic signed [SAMPLE_WIDTH-1:0] upper_bound,
    input  wire logic        [1:0]              operation,
    output logic                                done,
    output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);

    localparam int W    = SAMPLE_WIDTH;
    localparam int AW   = W + 1;   // offset magnitude, divisor and remainder width
    localparam int NSTG = AW;      // one remainder bit per stage

    typedef struct packed {
        logic signed [W-1:0] lo;
        logic signed [W-1:0] early;      // clip, pass or empty-range result
        logic                use_early;
        logic                fold;
        logic                neg;        // offset below zero
        logic [AW-1:0]       div;        // twice the range
    } side_t;

    // ---------------------------------------------------------------- entry
    logic signed [AW-1:0] offs;
    logic signed [AW-1:0] rng;
    logic [AW-1:0]        mag;
    logic                 rng_ok;
    logic signed [W-1:0]  clip_val;
    side_t                side_in;
    scwf_pkg::op_t        op;

    assign busy = 1'b0;
    assign op   = operation;

    always_comb
    begin
        offs     = {sample_in[W-1], sample_in} - {lower_bound[W-1], lower_bound};
        rng      = {upper_bound[W-1], upper_bound} - {lower_bound[W-1], lower_bound};
        mag      = offs[AW-1] ? AW'(-offs) : AW'(offs);
        rng_ok   = !rng[AW-1] && (rng != '0);
        if (sample_in < lower_bound)
            clip_val = lower_bound;
        else if (sample_in > upper_bound)
            clip_val = upper_bound;
        else
            clip_val = sample_in;

        side_in.lo   = lower_bound;
        side_in.fold = (op == scwf_pkg::OP_FOLD);
        side_in.neg  = offs[AW-1];
        side_in.div  = {rng[W-1:0], 1'b0};
        unique case (op)
            scwf_pkg::OP_CLIP:
            begin
                side_in.early     = clip_val;
                side_in.use_early = 1'b1;
            end
            scwf_pkg::OP_PASS:
            begin
                side_in.early     = sample_in;
                side_in.use_early = 1'b1;
            end
            default:
            begin
                side_in.early     = lower_bound;
                side_in.use_early = !rng_ok;
            end
        endcase
    end

    // ------------------------------------------------------ remainder stages
    logic          vld_reg  [NSTG+1];
    logic [AW-1:0] rem_reg  [NSTG+1];
    logic [AW-1:0] a_reg    [NSTG+1];
    side_t         side_reg [NSTG+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        a_reg[0]    <= mag;
        side_reg[0] <= side_in;
    end

    for (genvar k = 0; k < NSTG; k++)
    begin : g_div
        logic [AW:0]   trial;
        logic [AW-1:0] rem_next;

        always_comb
        begin
            trial = {rem_reg[k], a_reg[k][AW-1]};
            // restore: keep the shifted remainder unless the divisor fits
            if (trial >= {1'b0, side_reg[k].div})
                rem_next = AW'(trial - {1'b0, side_reg[k].div});
            else
                rem_next = trial[AW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_next;
            a_reg[k+1]    <= {a_reg[k][AW-2:0], 1'b0};
            side_reg[k+1] <= side_reg[k];
        end
    end

    // --------------------------------------------------------- finish stages
    logic          f1_vld_reg;
    logic [AW-1:0] d_reg;
    logic [AW-1:0] d_next;
    side_t         f1_side_reg;

    logic          f2_vld_reg;
    logic [W-1:0]  v_reg;
    logic [W-1:0]  v_next;
    logic [AW-1:0] half;
    side_t         f2_side_reg;

    logic                done_reg;
    logic signed [W-1:0] out_reg;
    logic signed [W-1:0] out_next;

    always_comb
    begin
        // floor the remainder for a negative offset
        if (side_reg[NSTG].neg && (rem_reg[NSTG] != '0))
            d_next = side_reg[NSTG].div - rem_reg[NSTG];
        else
            d_next = rem_reg[NSTG];
    end

    always_comb
    begin
        half = {1'b0, f1_side_reg.div[AW-1:1]};
        if (d_reg < half)
            v_next = d_reg[W-1:0];
        else if (f1_side_reg.fold)
            v_next = W'(f1_side_reg.div - d_reg);
        else
            v_next = W'(d_reg - half);
    end

    always_comb
    begin
        if (f2_side_reg.use_early)
            out_next = f2_side_reg.early;
        else
            out_next = W'(f2_side_reg.lo + $signed(v_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            f1_vld_reg <= vld_reg[NSTG];
            f2_vld_reg <= f1_vld_reg;
            done_reg   <= f2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg       <= d_next;
        f1_side_reg <= side_reg[NSTG];
        v_reg       <= v_next;
        f2_side_reg <= f1_side_reg;
        out_reg     <= out_next;
    end

    assign done       = done_reg;
    assign sample_out = out_reg;

endmodule

`default_nettype wire
